// File: rtl/gnh_pkg.sv
// Shared types, constants and the arctangent table for the greedy next-hop selector.
package gnh_pkg;

  localparam int unsigned NODE_BITS_DEF    = 8;
  localparam int unsigned CORDIC_ITERS_DEF = 24;

  localparam logic [30:0] RAD_K       = 31'd1257642247;
  localparam logic [33:0] CORDIC_X0   = 34'd652032874;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [21:0] MILES_K     = 22'd3956391;
  localparam logic [24:0] INV_1000    = 25'd17179870;
  localparam logic [16:0] COST_MAX    = 17'h1ffff;
  localparam logic signed [30:0] LAT_LIM   = 31'sd90000000;
  localparam logic signed [30:0] HALF_TURN = 31'sd180000000;
  localparam logic signed [30:0] FULL_TURN = 31'sd360000000;

  typedef enum logic [1:0] {
    REG_GOAL_NODE = 2'd0,
    REG_GOAL_LAT  = 2'd1,
    REG_GOAL_LON  = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RAD_MUL,
    S_RAD_RND,
    S_ROT,
    S_MUL_SL,
    S_MUL_C,
    S_MUL_SN,
    S_MUL_CS,
    S_A_SUM,
    S_SQRT,
    S_VEC,
    S_MI_MUL,
    S_DIV_MUL,
    S_TOTAL
  } state_t;

  // atan(2^-i) in Q2.30
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048576;
      5'd31: v = '0;
      default: v = 31'(1) << (5'd30 - i);
    endcase
    return v;
  endfunction

endpackage

// File: rtl/greedy_next_hop_haversine_select.sv
// Greedy next-hop selector: haversine heuristic per edge, running minimum, result on last edge.
//
//  channel  dir  handshake                 contents
//  s_axis   in   s_tvalid/s_tready         one out-edge, tlast = last_edge
//  m_axis   out  m_tvalid/m_tready         chosen neighbor, cost, goal flags
//  apb      in   psel/penable/pwrite       goal_node, goal_lat, goal_lon
//
// Each edge passes through the single CORDIC stage, the bit-serial square root and the
// one multiplier that the multiply steps share; a new edge is not taken before the last
// one is through, since s_tready is high only in the idle state. A finished result
// waits in the output register; a later last edge holds in its final step until that
// register is free. Synchronous reset clears the goal registers and returns the
// running minimum to the maximum cost.
module greedy_next_hop_haversine_select
  import gnh_pkg::*;
#(
  parameter int unsigned NODE_BITS    = NODE_BITS_DEF,
  parameter int unsigned CORDIC_ITERS = CORDIC_ITERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // current_node[7:0], neighbor_node[15:8], edge_miles[31:16],
  // neighbor_lat[59:32], neighbor_lon[88:60], zero fill
  input  logic [95:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // next_node[7:0], best_total[24:8], reaches_goal[25], already_at_goal[26], zero fill
  output logic [31:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NW = (NODE_BITS < 8) ? NODE_BITS : 8;
  localparam logic [4:0]  IT_LAST = 5'(CORDIC_ITERS - 1);

  state_t state, state_next;

  logic [7:0]         goal_node;
  logic signed [27:0] goal_lat;
  logic signed [28:0] goal_lon;

  logic [NW-1:0]      cur_node, nb_node;
  logic [15:0]        edge_miles;
  logic signed [27:0] nb_lat;
  logic signed [28:0] nb_lon;
  logic               last_edge;

  logic [16:0]        best_cost;
  logic [NW-1:0]      best_neighbor;

  logic [1:0]         k;
  logic [4:0]         it;
  logic               vec_mode;
  logic signed [33:0] cx, cy, cz;
  logic signed [33:0] sl, sn, c1, c2;
  logic signed [33:0] aterm, tc;
  logic [30:0]        a_q, sqrt_y;
  logic [62:0]        sq_n, sq_r, sq_bit;
  logic [4:0]         sq_cnt;
  logic               sq_pass;
  logic               sq_load;
  logic [32:0]        c_q;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_node <= '0;
      goal_lat  <= '0;
      goal_lon  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_GOAL_NODE: goal_node <= pwdata[7:0];
        REG_GOAL_LAT:  goal_lat  <= pwdata[27:0];
        REG_GOAL_LON:  goal_lon  <= pwdata[28:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GOAL_NODE: prdata = {24'd0, goal_node};
      REG_GOAL_LAT:  prdata = {4'd0, goal_lat};
      REG_GOAL_LON:  prdata = {3'd0, goal_lon};
      default:       prdata = '0;
    endcase
  end

  // ---------------- angle sources ----------------
  logic signed [30:0] lat1, lat2, dlat, dlon_raw, dlon, rad_src;
  logic [30:0]        rad_mag;
  logic signed [30:0] glat_x, nlat_x;

  assign glat_x = 31'(goal_lat);
  assign nlat_x = 31'(nb_lat);
  assign lat1 = (nlat_x > LAT_LIM) ? LAT_LIM : ((nlat_x < -LAT_LIM) ? -LAT_LIM : nlat_x);
  assign lat2 = (glat_x > LAT_LIM) ? LAT_LIM : ((glat_x < -LAT_LIM) ? -LAT_LIM : glat_x);
  assign dlat = lat2 - lat1;
  assign dlon_raw = 31'(goal_lon) - 31'(nb_lon);
  assign dlon = (dlon_raw > HALF_TURN) ? dlon_raw - FULL_TURN :
                ((dlon_raw < -HALF_TURN) ? dlon_raw + FULL_TURN : dlon_raw);

  always_comb begin
    case (k)
      2'd0:    rad_src = dlat;
      2'd1:    rad_src = dlon;
      2'd2:    rad_src = lat1;
      default: rad_src = lat2;
    endcase
  end
  assign rad_mag = rad_src[30] ? 31'(-rad_src) : rad_src;

  // rounding: half angle shifts by 27, full angle by 26
  logic [67:0] rad_sum;
  logic [33:0] rad_r;
  assign rad_sum = (k[1] == 1'b0) ? mul_p + 68'(1 << 26) : mul_p + 68'(1 << 25);
  assign rad_r = (k[1] == 1'b0) ? 34'(rad_sum >> 27) : 34'(rad_sum >> 26);

  // ---------------- shared multiplier ----------------
  always_comb begin
    case (state)
      S_RAD_MUL: begin mul_a = 34'(rad_mag);       mul_b = 34'(RAD_K);      end
      S_MUL_SL:  begin mul_a = sl;                 mul_b = sl;              end
      S_MUL_C:   begin mul_a = c1;                 mul_b = c2;              end
      S_MUL_SN:  begin mul_a = sn;                 mul_b = sn;              end
      S_MUL_CS:  begin mul_a = tc;                 mul_b = mul_p[63:30];    end
      S_MI_MUL:  begin mul_a = 34'(c_q);           mul_b = 34'(MILES_K);    end
      S_DIV_MUL: begin mul_a = 34'(mul_p[53:30]);  mul_b = 34'(INV_1000);   end
      default:   begin mul_a = '0;                 mul_b = '0;              end
    endcase
  end

  // ---------------- shared CORDIC stage ----------------
  logic signed [33:0] dx, dy, at, cx_next, cy_next, cz_next;
  logic               cneg;
  assign dx = cy >>> it;
  assign dy = cx >>> it;
  assign at = 34'(atan_q30(it));
  assign cneg = vec_mode ? cy[33] : !cz[33];
  assign cx_next = cneg ? cx - dx : cx + dx;
  assign cy_next = cneg ? cy + dy : cy - dy;
  assign cz_next = cneg ? cz - at : cz + at;

  // ---------------- bit-serial square root ----------------
  logic [62:0] sq_trial, sq_n_next, sq_r_next;
  logic        sq_ge;
  assign sq_trial  = sq_r + sq_bit;
  assign sq_ge     = sq_n >= sq_trial;
  assign sq_n_next = sq_ge ? sq_n - sq_trial : sq_n;
  assign sq_r_next = sq_ge ? (sq_r >> 1) + sq_bit : (sq_r >> 1);

  logic signed [34:0] a_sum;
  assign a_sum = 35'(aterm) + 35'(signed'(mul_p[63:30]));

  logic [16:0] miles;
  logic [17:0] tot_sum;
  logic [16:0] total;
  logic        out_free;
  assign miles   = mul_p[50:34];
  assign tot_sum = {2'd0, edge_miles} + {1'b0, miles};
  assign total   = tot_sum[17] ? COST_MAX : tot_sum[16:0];
  assign out_free = !m_tvalid || m_tready;

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (s_tvalid) state_next = S_RAD_MUL;
      S_RAD_MUL: state_next = S_RAD_RND;
      S_RAD_RND: state_next = S_ROT;
      S_ROT:     if (it == IT_LAST) state_next = (k == 2'd3) ? S_MUL_SL : S_RAD_MUL;
      S_MUL_SL:  state_next = S_MUL_C;
      S_MUL_C:   state_next = S_MUL_SN;
      S_MUL_SN:  state_next = S_MUL_CS;
      S_MUL_CS:  state_next = S_A_SUM;
      S_A_SUM:   state_next = S_SQRT;
      S_SQRT:    if (sq_cnt == 5'd31 && sq_pass && !sq_load) state_next = S_VEC;
      S_VEC:     if (it == IT_LAST) state_next = S_MI_MUL;
      S_MI_MUL:  state_next = S_DIV_MUL;
      S_DIV_MUL: state_next = S_TOTAL;
      S_TOTAL:   if (!last_edge || out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    // hold the scaled distance while the total waits for the output
    if (state != S_TOTAL) mul_p <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        cur_node   <= s_tdata[NW-1:0];
        nb_node    <= s_tdata[8 +: NW];
        edge_miles <= s_tdata[31:16];
        nb_lat     <= s_tdata[59:32];
        nb_lon     <= s_tdata[88:60];
        last_edge  <= s_tlast;
        k          <= '0;
      end
      S_RAD_RND: begin
        cz       <= rad_src[30] ? -rad_r : rad_r;
        cx       <= CORDIC_X0;
        cy       <= '0;
        it       <= '0;
        vec_mode <= 1'b0;
      end
      S_ROT, S_VEC: begin
        cx <= cx_next;
        cy <= cy_next;
        cz <= cz_next;
        it <= it + 5'd1;
        if (state == S_ROT && it == IT_LAST) begin
          case (k)
            2'd0:    sl <= cy_next;
            2'd1:    sn <= cy_next;
            2'd2:    c1 <= cx_next;
            default: c2 <= cx_next;
          endcase
          k <= k + 2'd1;
        end
        if (state == S_VEC && it == IT_LAST)
          c_q <= cz_next[33] ? '0 : {cz_next[31:0], 1'b0};
      end
      S_MUL_C:  aterm <= mul_p[63:30];
      S_MUL_SN: tc    <= mul_p[63:30];
      S_A_SUM: begin
        if (a_sum[34])                   a_q <= '0;
        else if (a_sum > 35'(ONE_Q30))   a_q <= ONE_Q30;
        else                             a_q <= a_sum[30:0];
        sq_n    <= '0;
        sq_r    <= '0;
        sq_bit  <= 63'(1) << 62;
        sq_cnt  <= '0;
        sq_pass <= 1'b0;
        sq_load <= 1'b1;
      end
      S_SQRT: begin
        // first cycle of each pass loads the radicand
        if (sq_load) begin
          sq_n    <= {2'd0, (sq_pass ? ONE_Q30 - a_q : a_q), 30'd0};
          sq_load <= 1'b0;
        end else if (sq_cnt != 5'd31) begin
          sq_n   <= sq_n_next;
          sq_r   <= sq_r_next;
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 5'd1;
        end else if (!sq_pass) begin
          sqrt_y  <= sq_r_next[30:0];
          sq_r    <= '0;
          sq_bit  <= 63'(1) << 62;
          sq_cnt  <= '0;
          sq_pass <= 1'b1;
          sq_load <= 1'b1;
        end else begin
          cx       <= 34'(sq_r_next[30:0]);
          cy       <= 34'(sqrt_y);
          cz       <= '0;
          it       <= '0;
          vec_mode <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------- running minimum and result ----------------
  logic          upd;
  logic          emit;
  logic [16:0]   cost_eff;
  logic [NW-1:0] nb_eff, goal_m;
  assign upd      = total < best_cost;
  assign cost_eff = upd ? total : best_cost;
  assign nb_eff   = upd ? nb_node : best_neighbor;
  assign goal_m   = goal_node[NW-1:0];
  assign emit     = (state == S_TOTAL) && (state_next == S_IDLE) && last_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_cost     <= COST_MAX;
      best_neighbor <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (emit)          m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (state == S_TOTAL && state_next == S_IDLE) begin
        if (last_edge) begin
          m_tdata       <= {5'd0, (cur_node == goal_m), (nb_eff == goal_m),
                            cost_eff, 8'(nb_eff)};
          best_cost     <= COST_MAX;
          best_neighbor <= '0;
        end else begin
          best_cost     <= cost_eff;
          best_neighbor <= nb_eff;
        end
      end
    end
  end

endmodule

// File: tb/testbench.sv
// Testbench for the greedy next-hop selector: random edge groups, haversine predictor, scoreboard.
module testbench;
  import gnh_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 250;

  typedef struct {
    logic [7:0]  cur;
    logic [7:0]  nb;
    logic [15:0] miles;
    logic [27:0] lat;
    logic [28:0] lon;
    logic        last;
  } edge_item_t;

  typedef struct {
    logic [7:0]  next_node;
    logic [16:0] best_total;
    logic        reaches_goal;
    logic        already_at_goal;
  } hop_t;

  class route_scoreboard;
    logic [7:0]  goal_node;
    logic [27:0] goal_lat;
    logic [28:0] goal_lon;
    logic [16:0] best_cost;
    logic [7:0]  best_neighbor;
    hop_t        hops_due[$];
    int          mismatches;

    function new();
      goal_node     = '0;
      goal_lat      = '0;
      goal_lon      = '0;
      best_cost     = COST_MAX;
      best_neighbor = '0;
      mismatches    = 0;
    endfunction

    function int pending();
      return hops_due.size();
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_GOAL_NODE: goal_node = value[7:0];
        REG_GOAL_LAT:  goal_lat  = value[27:0];
        REG_GOAL_LON:  goal_lon  = value[28:0];
        default: ;
      endcase
    endfunction

    function longint arc_step(int i);
      longint head [11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
      if (i < 11) return head[i];
      if (i <= 30) return longint'(1) << (30 - i);
      return 0;
    endfunction

    function longint qmul(longint a, longint b);
      return (a * b) >>> 30;
    endfunction

    // microdegrees to Q2.30 radians, rounded on the magnitude
    function longint micro_to_rad(longint m, int s);
      longint mag;
      longint r;
      mag = (m < 0) ? -m : m;
      r = (mag * longint'(RAD_K) + (longint'(1) << (s - 1))) >>> s;
      return (m < 0) ? -r : r;
    endfunction

    function void sin_cos(longint z, output longint c, output longint s);
      longint x;
      longint y;
      longint dx;
      longint dy;
      x = longint'(CORDIC_X0);
      y = 0;
      for (int i = 0; i < CORDIC_ITERS_DEF; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - arc_step(i);
        end else begin
          x = x + dx; y = y - dy; z = z + arc_step(i);
        end
      end
      c = x;
      s = y;
    endfunction

    function longint arctan2(longint x, longint y);
      longint z;
      longint dx;
      longint dy;
      z = 0;
      for (int i = 0; i < CORDIC_ITERS_DEF; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y < 0) begin
          x = x - dx; y = y + dy; z = z - arc_step(i);
        end else begin
          x = x + dx; y = y - dy; z = z + arc_step(i);
        end
      end
      return z;
    endfunction

    function longint root_q30(longint v);
      longint unsigned n;
      longint unsigned r;
      longint unsigned bitv;
      n = longint'(v) << 30;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= r + bitv) begin
          n = n - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
      return longint'(r);
    endfunction

    function longint clamp_lat(longint v);
      if (v > 90000000) return 90000000;
      if (v < -90000000) return -90000000;
      return v;
    endfunction

    function longint miles_to_goal(longint nlat, longint nlon);
      longint lat1, lat2, dlon, c1, s1, c2, s2, cl, sl, cn, sn, a, c;
      longint unsigned cu;
      lat1 = clamp_lat(nlat);
      lat2 = clamp_lat(longint'(signed'(goal_lat)));
      dlon = longint'(signed'(goal_lon)) - nlon;
      while (dlon > 180000000) dlon = dlon - 360000000;
      while (dlon < -180000000) dlon = dlon + 360000000;
      sin_cos(micro_to_rad(lat2 - lat1, 27), cl, sl);
      sin_cos(micro_to_rad(dlon, 27), cn, sn);
      sin_cos(micro_to_rad(lat1, 26), c1, s1);
      sin_cos(micro_to_rad(lat2, 26), c2, s2);
      a = qmul(sl, sl) + qmul(qmul(c1, c2), qmul(sn, sn));
      if (a < 0) a = 0;
      if (a > (longint'(1) << 30)) a = longint'(1) << 30;
      c = 2 * arctan2(root_q30((longint'(1) << 30) - a), root_q30(a));
      if (c < 0) c = 0;
      cu = c;
      return longint'((cu * 64'd3956391) / (64'd1000 << 30));
    endfunction

    function void note_edge(edge_item_t it);
      longint total;
      hop_t   h;
      total = longint'(it.miles) +
              miles_to_goal(longint'(signed'(it.lat)), longint'(signed'(it.lon)));
      if (total > longint'(COST_MAX)) total = longint'(COST_MAX);
      if (total < longint'(best_cost)) begin
        best_cost     = total[16:0];
        best_neighbor = it.nb;
      end
      if (it.last) begin
        h.next_node       = best_neighbor;
        h.best_total      = best_cost;
        h.reaches_goal    = (best_neighbor == goal_node);
        h.already_at_goal = (it.cur == goal_node);
        hops_due = {hops_due, h};
        best_cost     = COST_MAX;
        best_neighbor = '0;
      end
    endfunction

    function void check_hop(logic [31:0] data);
      hop_t h;
      if (hops_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", data);
        return;
      end
      h = hops_due.pop_front();
      if (data[7:0] !== h.next_node || data[24:8] !== h.best_total ||
          data[25] !== h.reaches_goal || data[26] !== h.already_at_goal) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp node %0d total %0d goal %b at %b, got node %0d total %0d goal %b at %b",
                   h.next_node, h.best_total, h.reaches_goal, h.already_at_goal,
                   data[7:0], data[24:8], data[25], data[26]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  route_scoreboard sb;
  int unsigned     idle_cycles;
  int unsigned     burst_left;
  int unsigned     ready_phase;
  int unsigned     ready_mode;

  greedy_next_hop_haversine_select DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: stall pattern drawn at random from four modes
  always @(posedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      ready_phase <= 0;
      ready_mode  <= 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_hop(m_tdata);
      ready_phase <= ready_phase + 1;
      if (ready_phase % 64 == 63) ready_mode <= $urandom_range(3);
      case (ready_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(1));
        2: m_tready <= ($urandom_range(7) == 0);
        default: m_tready <= (ready_phase % 32) > 20;
      endcase
    end
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic apb_write(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_goal(logic [7:0] node, int lat, int lon);
    apb_write(REG_GOAL_NODE, {24'd0, node});
    apb_write(REG_GOAL_LAT, {4'd0, lat[27:0]});
    apb_write(REG_GOAL_LON, {3'd0, lon[28:0]});
  endtask

  task automatic send_edge(edge_item_t it);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, it.lon, it.lat, it.miles, it.nb, it.cur};
    s_tlast  <= it.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_edge(it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(12);
      gap = $urandom_range(15);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic edge_item_t make_edge(logic [7:0] cur, logic last);
    edge_item_t it;
    it.cur  = cur;
    it.nb   = ($urandom_range(5) == 0) ? sb.goal_node : 8'($urandom);
    case ($urandom_range(5))
      0: it.miles = 16'd0;
      1: it.miles = 16'hffff;
      2: it.miles = 16'($urandom_range(500));
      default: it.miles = 16'($urandom);
    endcase
    if ($urandom_range(9) == 0) it.lat = 28'($urandom);
    else it.lat = 28'(int'($urandom_range(180000000)) - 90000000);
    if ($urandom_range(9) == 0) it.lon = 29'($urandom);
    else it.lon = 29'(int'($urandom_range(360000000)) - 180000000);
    if ($urandom_range(7) == 0) begin
      it.lat = sb.goal_lat;
      it.lon = sb.goal_lon;
    end
    it.last = last;
    return it;
  endfunction

  task automatic send_random_groups(int unsigned count);
    int unsigned sent;
    int unsigned group;
    logic [7:0]  cur;
    sent = 0;
    while (sent < count) begin
      group = ($urandom_range(9) == 0) ? $urandom_range(20, 1) : $urandom_range(6, 1);
      cur   = ($urandom_range(5) == 0) ? sb.goal_node : 8'($urandom);
      for (int unsigned k = 1; k <= group; k++) begin
        send_edge(make_edge(cur, k == group));
        sent++;
      end
    end
  endtask

  initial begin
    edge_item_t it;
    sb         = new();
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, ties, goal hits, out-of-range coordinates
    set_goal(8'd5, 40000000, -75000000);
    it = '{cur: 8'd1, nb: 8'd10, miles: 16'd0, lat: 28'(90000000), lon: 29'(180000000), last: 1'b0};
    send_edge(it);
    it = '{cur: 8'd1, nb: 8'd11, miles: 16'hffff, lat: 28'(-90000000), lon: 29'(-180000000), last: 1'b0};
    send_edge(it);
    it = '{cur: 8'd1, nb: 8'd5, miles: 16'd3, lat: 28'(40000000), lon: 29'(-75000000), last: 1'b1};
    send_edge(it);
    // equal totals: first one stays
    it = '{cur: 8'd5, nb: 8'd20, miles: 16'd7, lat: 28'(10000000), lon: 29'(20000000), last: 1'b0};
    send_edge(it);
    it = '{cur: 8'd5, nb: 8'd21, miles: 16'd7, lat: 28'(10000000), lon: 29'(20000000), last: 1'b1};
    send_edge(it);
    it = '{cur: 8'd255, nb: 8'd255, miles: 16'hffff, lat: 28'h7ffffff, lon: 29'h0fffffff, last: 1'b0};
    send_edge(it);
    it = '{cur: 8'd255, nb: 8'd0, miles: 16'hffff, lat: 28'h8000000, lon: 29'h10000000, last: 1'b1};
    send_edge(it);
    // antipode of the goal
    it = '{cur: 8'd0, nb: 8'd9, miles: 16'd1, lat: 28'(-40000000), lon: 29'(105000000), last: 1'b1};
    send_edge(it);
    drain();

    set_goal(8'd0, 0, 0);
    send_random_groups(90);
    drain();
    set_goal(8'd255, 90000000, 180000000);
    send_random_groups(90);
    drain();
    set_goal(8'd17, -90000000, -180000000);
    send_random_groups(90);
    drain();
    for (int p = 0; p < 3; p++) begin
      set_goal(8'($urandom), int'($urandom_range(180000000)) - 90000000,
               int'($urandom_range(360000000)) - 180000000);
      send_random_groups(90);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
